/* rtl/core/mbq_pkg.sv */
package mbq_pkg;

    // Frame limits.
    localparam int MAX_PIXELS = 1048576;
    localparam int MAX_DIM    = 4096;

    // Width of the selected-pixel count and of one histogram bin.
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);

    // Width that holds any position or MAX_DIM itself for the bounds check.
    localparam int DIM_CMP_W = 17;

    // Histogram geometry.
    localparam int NUM_BINS = 256;
    localparam int BIN_AW   = 8;

    // Queue between the classifier and the histogram engine.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_H = 2'd3;

    // One classified pixel as it travels through the queue.
    typedef struct packed {
        logic [7:0] gray;
        logic       sel;
        logic       last;
    } pix_item_t;

    // Histogram engine states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_WALK,
        ST_FLUSH,
        ST_EMIT
    } back_state_t;

endpackage

/* rtl/core/masked_brightness_quartiles_unit.sv */
// Masked brightness quartiles.
//
// Pixels arrive on the s_ channel, one item per gray pixel with its mask byte,
// column, row and end-of-frame flag. A pixel is counted when its mask is
// nonzero and it lies inside the scan rectangle set through the cfg_ port
// (zero width or height selects the whole image). The user must write the
// registers only while the block is idle; the block does not enforce this.
// One result item per frame leaves on the m_ channel after the frame_end pixel:
// the levels at ranks n/4, n/2, 3n/4 and n-1, an empty flag and a count
// saturation flag.
// Outside the walk, the clearing pass and a stalled result, throughput is
// one pixel per cycle, set by the read-modify-write of the histogram memory,
// which forwards a bin written in the previous cycle. After a frame_end pixel
// with a nonzero count the engine walks all 256 bins through the memory read
// port, one bin per cycle, clearing each bin behind it, and then emits the
// result. Pixels keep entering a four-entry queue meanwhile and wait there.
// Reset clears the count and flags and then runs a clearing pass over all
// 256 histogram bins, during which s_ready stays low.
// If the receiver stalls, the result is held in the output register; a later
// result waits in the engine until taken; intake stops when the queue fills.
module masked_brightness_quartiles_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [mbq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_gray_level,
    input  logic [7:0]                     s_mask_value,
    input  logic [11:0]                    s_col,
    input  logic [11:0]                    s_row,
    input  logic                           s_frame_end,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_quart_one,
    output logic [7:0]                     m_quart_two,
    output logic [7:0]                     m_quart_three,
    output logic [7:0]                     m_max_level,
    output logic                           m_empty_res,
    output logic                           m_overflow
);
    import mbq_pkg::*;

    pix_item_t push_item;
    pix_item_t pop_item;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_nonempty;
    logic      clearing;

    // Classifier and configuration registers.
    mbq_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_gray_level (s_gray_level),
        .s_mask_value (s_mask_value),
        .s_col        (s_col),
        .s_row        (s_row),
        .s_frame_end  (s_frame_end),
        .q_full       (q_full),
        .clearing     (clearing),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    // Queue between classifier and histogram engine.
    mbq_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .nonempty  (q_nonempty)
    );

    // Histogram engine and result register.
    mbq_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_item        (pop_item),
        .q_nonempty    (q_nonempty),
        .q_pop         (q_pop),
        .clearing      (clearing),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_quart_one   (m_quart_one),
        .m_quart_two   (m_quart_two),
        .m_quart_three (m_quart_three),
        .m_max_level   (m_max_level),
        .m_empty_res   (m_empty_res),
        .m_overflow    (m_overflow)
    );

endmodule

/* rtl/core/mbq_front.sv */
module mbq_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [mbq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_gray_level,
    input  logic [7:0]                     s_mask_value,
    input  logic [11:0]                    s_col,
    input  logic [11:0]                    s_row,
    input  logic                           s_frame_end,
    input  logic                           q_full,
    input  logic                           clearing,
    output logic                           q_push,
    output mbq_pkg::pix_item_t             q_item
);
    import mbq_pkg::*;

    logic [11:0] region_x_reg;
    logic [11:0] region_y_reg;
    logic [12:0] region_w_reg;
    logic [12:0] region_h_reg;

    logic        in_image;
    logic        whole_image;
    logic        col_in;
    logic        row_in;
    logic [13:0] col_end;
    logic [13:0] row_end;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_x_reg <= '0;
            region_y_reg <= '0;
            region_w_reg <= '0;
            region_h_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_REGION_X: region_x_reg <= cfg_wdata[11:0];
                CFG_REGION_Y: region_y_reg <= cfg_wdata[11:0];
                CFG_REGION_W: region_w_reg <= cfg_wdata;
                CFG_REGION_H: region_h_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Position tests against the image bounds and the scan rectangle.
    assign in_image = (DIM_CMP_W'(s_col) < DIM_CMP_W'(MAX_DIM))
                   && (DIM_CMP_W'(s_row) < DIM_CMP_W'(MAX_DIM));
    assign whole_image = (region_w_reg == '0) || (region_h_reg == '0);
    assign col_end = {2'b00, region_x_reg} + {1'b0, region_w_reg};
    assign row_end = {2'b00, region_y_reg} + {1'b0, region_h_reg};
    assign col_in = (s_col >= region_x_reg) && ({2'b00, s_col} < col_end);
    assign row_in = (s_row >= region_y_reg) && ({2'b00, s_row} < row_end);

    // The item enters the queue with its selection already decided.
    assign s_ready     = !q_full && !clearing;
    assign q_push      = s_valid && s_ready;
    assign q_item.gray = s_gray_level;
    assign q_item.sel  = (s_mask_value != 8'd0) && in_image
                      && (whole_image || (col_in && row_in));
    assign q_item.last = s_frame_end;

endmodule

/* rtl/core/mbq_fifo.sv */
module mbq_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  mbq_pkg::pix_item_t push_item,
    output logic               full,
    input  logic               pop,
    output mbq_pkg::pix_item_t pop_item,
    output logic               nonempty
);
    import mbq_pkg::*;

    pix_item_t         entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full     = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_item = entry_reg[rptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/mbq_back.sv */
module mbq_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  mbq_pkg::pix_item_t q_item,
    input  logic               q_nonempty,
    output logic               q_pop,
    output logic               clearing,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_quart_one,
    output logic [7:0]         m_quart_two,
    output logic [7:0]         m_quart_three,
    output logic [7:0]         m_max_level,
    output logic               m_empty_res,
    output logic               m_overflow
);
    import mbq_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

    // Histogram memory and its registered read port.
    logic [CNT_W-1:0]  hist_mem [NUM_BINS];
    logic [CNT_W-1:0]  rdata_reg;
    logic              mem_we;
    logic [BIN_AW-1:0] mem_waddr;
    logic [CNT_W-1:0]  mem_wdata;
    logic [BIN_AW-1:0] mem_raddr;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [BIN_AW-1:0] idx_reg;
    logic              idx_run;

    // Update stage.
    logic              s1_valid_reg;
    pix_item_t         s1_item_reg;
    logic              fwd_valid_reg;
    logic [BIN_AW-1:0] fwd_addr_reg;
    logic [CNT_W-1:0]  fwd_data_reg;
    logic [CNT_W-1:0]  bin_cur;
    logic              s1_hit;
    logic              can_add;
    logic              frame_done;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              sat_reg;
    logic              sat_next;

    // Histogram walk.
    logic              walk_init;
    logic              walk_vld_reg;
    logic [BIN_AW-1:0] walk_bin_reg;
    logic [CNT_W-1:0]  acc_reg;
    logic [CNT_W-1:0]  acc_next;
    logic [CNT_W-1:0]  rank_reg  [4];
    logic [CNT_W-1:0]  rank_calc [4];
    logic [CNT_W+1:0]  cnt_x3;
    logic [3:0]        found_reg;
    logic [7:0]        level_reg [4];

    logic              emit_load;
    logic              m_valid_reg;
    logic              out_empty;

    // Memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= hist_mem[mem_raddr];
    end

    // A bin written in the same cycle as it was read is taken from here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= mem_we;
        end
        fwd_addr_reg <= mem_waddr;
        fwd_data_reg <= mem_wdata;
    end

    assign bin_cur = (fwd_valid_reg && (fwd_addr_reg == s1_item_reg.gray))
                   ? fwd_data_reg : rdata_reg;
    assign s1_hit     = s1_valid_reg && s1_item_reg.sel;
    assign can_add    = (cnt_reg < MAX_CNT);
    assign frame_done = s1_valid_reg && s1_item_reg.last;

    // Pixel count and saturation flag.
    always_comb begin
        cnt_next = cnt_reg;
        sat_next = sat_reg;
        if (state_reg == ST_RUN && s1_hit) begin
            if (can_add) begin
                cnt_next = cnt_reg + 1'b1;
            end else begin
                sat_next = 1'b1;
            end
        end
        if (emit_load) begin
            cnt_next = '0;
            sat_next = 1'b0;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (idx_reg == '1) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (frame_done) begin
                    state_next = (cnt_next == '0) ? ST_EMIT : ST_WALK;
                end
            end
            ST_WALK: begin
                if (idx_reg == '1) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // State outputs: memory port selection and queue control.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = s1_item_reg.gray;
        mem_wdata = '0;
        mem_raddr = q_item.gray;
        q_pop     = 1'b0;
        idx_run   = 1'b0;
        walk_init = 1'b0;
        emit_load = 1'b0;
        clearing  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                clearing  = 1'b1;
                idx_run   = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
            end
            ST_RUN: begin
                q_pop     = q_nonempty && !frame_done;
                mem_we    = s1_hit && can_add;
                mem_wdata = bin_cur + 1'b1;
            end
            ST_WALK: begin
                idx_run   = 1'b1;
                walk_init = (idx_reg == '0);
                mem_raddr = idx_reg;
                mem_we    = walk_vld_reg;
                mem_waddr = walk_bin_reg;
            end
            ST_FLUSH: begin
                mem_we    = walk_vld_reg;
                mem_waddr = walk_bin_reg;
            end
            ST_EMIT: begin
                emit_load = !m_valid_reg || m_ready;
            end
            default: ;
        endcase
    end

    // Target ranks: n/4, n/2, 3n/4 and n-1.
    assign cnt_x3       = {2'b00, cnt_reg} + {1'b0, cnt_reg, 1'b0};
    assign rank_calc[0] = {2'b00, cnt_reg[CNT_W-1:2]};
    assign rank_calc[1] = {1'b0, cnt_reg[CNT_W-1:1]};
    assign rank_calc[2] = cnt_x3[CNT_W+1:2];
    assign rank_calc[3] = cnt_reg - 1'b1;

    assign acc_next = acc_reg + rdata_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            sat_reg      <= 1'b0;
            walk_vld_reg <= 1'b0;
            found_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s1_valid_reg <= q_pop;
            cnt_reg      <= cnt_next;
            sat_reg      <= sat_next;
            walk_vld_reg <= (state_reg == ST_WALK);
            if (idx_run) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (walk_init) begin
                found_reg <= '0;
            end else if (walk_vld_reg) begin
                for (int j = 0; j < 4; j++) begin
                    if (!found_reg[j] && (acc_next > rank_reg[j])) begin
                        found_reg[j] <= 1'b1;
                    end
                end
            end
            if (emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Update stage payload.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_item_reg <= q_item;
        end
    end

    // Walk datapath: running sum and the first bin past each rank.
    always_ff @(posedge aclk) begin
        walk_bin_reg <= idx_reg;
        if (walk_init) begin
            acc_reg <= '0;
            for (int j = 0; j < 4; j++) begin
                rank_reg[j]  <= rank_calc[j];
                level_reg[j] <= 8'hFF;
            end
        end else if (walk_vld_reg) begin
            acc_reg <= acc_next;
            for (int j = 0; j < 4; j++) begin
                if (!found_reg[j] && (acc_next > rank_reg[j])) begin
                    level_reg[j] <= walk_bin_reg;
                end
            end
        end
    end

    // Result register.
    assign out_empty = (cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_quart_one   <= out_empty ? 8'd0 : level_reg[0];
            m_quart_two   <= out_empty ? 8'd0 : level_reg[1];
            m_quart_three <= out_empty ? 8'd0 : level_reg[2];
            m_max_level   <= out_empty ? 8'd0 : level_reg[3];
            m_empty_res   <= out_empty;
            m_overflow    <= sat_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/core/mbq_checker.sv */
module mbq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_we,
    input logic [mbq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [mbq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [7:0]                     s_gray_level,
    input logic [7:0]                     s_mask_value,
    input logic [11:0]                    s_col,
    input logic [11:0]                    s_row,
    input logic                           s_frame_end,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [7:0]                     m_quart_one,
    input logic [7:0]                     m_quart_two,
    input logic [7:0]                     m_quart_three,
    input logic [7:0]                     m_max_level,
    input logic                           m_empty_res,
    input logic                           m_overflow
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_quart_one)
            && $stable(m_quart_two) && $stable(m_quart_three)
            && $stable(m_max_level) && $stable(m_empty_res) && $stable(m_overflow))
        else $error("result changed while stalled");

    // An empty frame reports zero levels and no saturation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_res |-> (m_quart_one == 8'd0) && (m_quart_two == 8'd0)
            && (m_quart_three == 8'd0) && (m_max_level == 8'd0) && !m_overflow)
        else $error("empty result carries data");

    // Levels at increasing ranks never decrease.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_empty_res |-> (m_quart_one <= m_quart_two)
            && (m_quart_two <= m_quart_three) && (m_quart_three <= m_max_level))
        else $error("rank levels out of order");

    // Reset drops the result and starts the clearing pass.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("block not quiet after reset");

endmodule

bind masked_brightness_quartiles_unit mbq_checker u_mbq_checker (.*);
